// ===== src/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU timestamp slot table package
// Shared types and constants for the slot table controller, its stamp memory
// and the stream wrapper.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int STAMP_W = 64;
    localparam int IDX_W   = 6;
    localparam int RESCALE_SHIFT = 48;
    localparam logic [STAMP_W-1:0] RESCALE_LIMIT = 64'h0FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_USE    = 2'd2,
        CMD_FIND   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_SCAN,
        S_USE_RD,
        S_USE_WR,
        S_FIND_WR,
        S_DONE
    } t_state;

    // one slot as kept in memory
    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // command item handed to the controller
    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        logic             all;
    } t_item;

    // finished result offered by the controller
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] slot;
        t_status          status;
    } t_result;

endpackage

// ===== src/lru_timestamp_slot_table.sv =====
// Add, and any out-of-range or full item, go straight from accept to the result.
// Remove clears the mark, then trims trailing free slots off the count; use restamps
// the slot, first rescaling every live stamp when the counter needs it; find scans every
// slot in use. One item at a time: the next item is taken in the cycle after the result
// enters the output register; scans read one slot per cycle.
// Reset clears the count, the counter and the handshake; memory needs no clearing.
// ----------------------------------------------------------------------------
// LRU timestamp slot table
// Slot table with 64-bit recency stamps, a use counter and least-recently-used
// search, kept in a single slot memory behind a stream interface.
// ----------------------------------------------------------------------------
module lru_timestamp_slot_table #(
    parameter int SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [5:0] slot_index, [6] include_taken, [7] zero
    input  logic [1:0] i_s_tuser,   // [1:0] command
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [5:0] result_slot, [7:6] zero
    output logic [1:0] o_m_tuser    // [1:0] status
);
    import lts_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_item            w_item;
    t_result          w_res;
    logic             w_res_ready;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    t_entry           w_wdata;
    t_entry           w_rdata;

    logic             r_out_vld;
    logic [IDX_W-1:0] r_out_slot;
    t_status          r_out_st;

    // unpack the incoming item
    assign w_item.cmd = t_cmd'(i_s_tuser);
    assign w_item.idx = i_s_tdata[IDX_W-1:0];
    assign w_item.all = i_s_tdata[IDX_W];

    lts_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_item      (w_item),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    lts_ram #(
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // output register: free when empty or being taken
    assign w_res_ready = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res.valid && w_res_ready) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_res_ready) begin
            r_out_slot <= w_res.slot;
            r_out_st   <= w_res.status;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_slot};
    assign o_m_tuser  = r_out_st;

endmodule

// ===== src/lts_ram.sv =====
// ----------------------------------------------------------------------------
// Slot memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lts_ram #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  lts_pkg::t_entry                    i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output lts_pkg::t_entry                    o_rdata
);
    import lts_pkg::*;

    t_entry r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/lts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot table sequencer
// Holds the use counter and slot count, and walks the slot memory for
// trimming, rescaling and the least-recently-used search.
// ----------------------------------------------------------------------------
module lts_ctrl #(
    parameter int SLOTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  lts_pkg::t_item                     i_item,
    output lts_pkg::t_result                   o_res,
    input  logic                               i_res_ready,
    output logic                               o_we,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_waddr,
    output lts_pkg::t_entry                    o_wdata,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_raddr,
    input  lts_pkg::t_entry                    i_rdata
);
    import lts_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [STAMP_W-1:0]  r_ctr, n_ctr;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic                r_rd_vld, n_rd_vld;
    logic [AW-1:0]       r_rd_addr, n_rd_addr;
    logic [STAMP_W-1:0]  r_best, n_best;
    logic [AW-1:0]       r_res, n_res;
    logic                r_found, n_found;
    logic                r_zero_vld, n_zero_vld;
    logic                r_all, n_all;
    logic                r_rescale, n_rescale;
    logic [AW-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]    r_pend_slot, n_pend_slot;
    t_status             r_pend_st, n_pend_st;

    logic                w_in_range;
    logic [CW-1:0]       w_cnt_m1;

    assign w_in_range = XW'(i_item.idx) < XW'(r_cnt);
    assign w_cnt_m1   = r_cnt - CW'(1);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ctr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ctr    <= n_ctr;
            r_rd_vld <= n_rd_vld;
        end
    end

    // scan and result payload
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_rd_addr   <= n_rd_addr;
        r_best      <= n_best;
        r_res       <= n_res;
        r_found     <= n_found;
        r_zero_vld  <= n_zero_vld;
        r_all       <= n_all;
        r_rescale   <= n_rescale;
        r_idx       <= n_idx;
        r_pend_slot <= n_pend_slot;
        r_pend_st   <= n_pend_st;
    end

    // next state, memory requests and result
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ctr       = r_ctr;
        n_ptr       = r_ptr;
        n_rd_vld    = 1'b0;
        n_rd_addr   = r_rd_addr;
        n_best      = r_best;
        n_res       = r_res;
        n_found     = r_found;
        n_zero_vld  = r_zero_vld;
        n_all       = r_all;
        n_rescale   = r_rescale;
        n_idx       = r_idx;
        n_pend_slot = r_pend_slot;
        n_pend_st   = r_pend_st;
        o_ready     = 1'b0;
        o_we        = 1'b0;
        o_waddr     = '0;
        o_wdata     = '0;
        o_raddr     = r_ptr[AW-1:0];
        o_res.valid  = 1'b0;
        o_res.slot   = r_pend_slot;
        o_res.status = r_pend_st;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_pend_slot = '0;
                    n_pend_st   = ST_OK;
                    n_state     = S_DONE;
                    case (i_item.cmd)
                        CMD_ADD: begin
                            if (r_cnt == CW'(SLOTS)) begin
                                n_pend_st = ST_FULL;
                            end else begin
                                o_we          = 1'b1;
                                o_waddr       = r_cnt[AW-1:0];
                                o_wdata.valid = 1'b1;
                                o_wdata.stamp = r_ctr + STAMP_W'(1);
                                n_ctr         = r_ctr + STAMP_W'(1);
                                n_cnt         = r_cnt + CW'(1);
                                n_pend_slot   = IDX_W'(r_cnt);
                            end
                        end
                        CMD_REMOVE: begin
                            if (!w_in_range) begin
                                n_pend_st = ST_RANGE;
                            end else begin
                                // clear the mark, then trim the tail
                                o_we    = 1'b1;
                                o_waddr = AW'(i_item.idx);
                                n_state = S_TRIM_RD;
                            end
                        end
                        CMD_USE: begin
                            if (!w_in_range) begin
                                n_pend_st = ST_RANGE;
                            end else begin
                                n_idx = AW'(i_item.idx);
                                if (r_ctr > RESCALE_LIMIT) begin
                                    n_ctr     = r_ctr >> RESCALE_SHIFT;
                                    n_rescale = 1'b1;
                                    n_ptr     = '0;
                                    n_state   = S_SCAN;
                                end else begin
                                    n_state = S_USE_RD;
                                end
                            end
                        end
                        CMD_FIND: begin
                            n_best     = r_ctr;
                            n_res      = '0;
                            n_found    = 1'b0;
                            n_zero_vld = 1'b0;
                            n_all      = i_item.all;
                            n_rescale  = 1'b0;
                            n_ptr      = '0;
                            n_state    = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // fetch the last counted slot
            S_TRIM_RD: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_raddr = w_cnt_m1[AW-1:0];
                    n_state = S_TRIM_CHK;
                end
            end

            // stop at a valid slot, otherwise drop it from the count
            S_TRIM_CHK: begin
                if (i_rdata.valid) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt   = w_cnt_m1;
                    n_state = S_TRIM_RD;
                end
            end

            // stream every counted slot through the read port
            S_SCAN: begin
                if (r_ptr != r_cnt) begin
                    o_raddr   = r_ptr[AW-1:0];
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                end
                if (r_rd_vld) begin
                    if (r_rescale) begin
                        if (i_rdata.valid) begin
                            o_we          = 1'b1;
                            o_waddr       = r_rd_addr;
                            o_wdata.valid = 1'b1;
                            o_wdata.stamp = (i_rdata.stamp >> RESCALE_SHIFT)
                                            + STAMP_W'(1);
                        end
                    end else begin
                        if (r_rd_addr == '0) begin
                            n_zero_vld = i_rdata.valid;
                        end
                        if (i_rdata.valid && (i_rdata.stamp < r_best) &&
                            (r_all || (i_rdata.stamp != '0))) begin
                            n_best  = i_rdata.stamp;
                            n_res   = r_rd_addr;
                            n_found = 1'b1;
                        end
                    end
                end
                // leave once issue is done and the last write has landed
                if ((r_ptr == r_cnt) && !r_rd_vld) begin
                    n_state = r_rescale ? S_USE_RD : S_FIND_WR;
                end
            end

            S_USE_RD: begin
                o_raddr = r_idx;
                n_state = S_USE_WR;
            end

            // restamp, keep the valid mark
            S_USE_WR: begin
                o_we          = 1'b1;
                o_waddr       = r_idx;
                o_wdata.valid = i_rdata.valid;
                o_wdata.stamp = r_ctr + STAMP_W'(1);
                n_ctr         = r_ctr + STAMP_W'(1);
                n_state       = S_DONE;
            end

            // unless taken slots are included, claim the chosen slot by zeroing its stamp
            S_FIND_WR: begin
                if (!r_all) begin
                    o_we          = 1'b1;
                    o_waddr       = r_res;
                    o_wdata.valid = r_found ? 1'b1 : r_zero_vld;
                    o_wdata.stamp = '0;
                end
                n_pend_slot = IDX_W'(r_res);
                n_state     = S_DONE;
            end

            S_DONE: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/tb_lru_timestamp_slot_table.sv =====
// ----------------------------------------------------------------------------
// LRU timestamp slot table testbench
// Streams add, remove, use and find items through the slot table and checks
// each result against an in-bench model of the table. A directed table comes
// first, then random segments biased toward filling or draining the table, or evenly mixed.
// The sender works in bursts and the receiver stalls in patterns, with one
// long hold-off that backs the table up.
// ----------------------------------------------------------------------------
module tb_lru_timestamp_slot_table;
    timeunit 1ns;
    timeprecision 1ps;

    import lts_pkg::*;

    localparam int SLOTS        = 64;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;

    // one expected result
    typedef struct packed {
        logic [IDX_W-1:0] slot;
        t_status          status;
    } t_lru_result;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        logic             incl;
        logic             typed;
        logic [IDX_W-1:0] slot;
        t_status          status;
    } t_stim_row;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = '0;   // [5:0] slot_index, [6] include_taken, [7] zero
    logic [1:0] i_s_tuser  = '0;   // [1:0] command
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;         // [5:0] result_slot, [7:6] zero
    logic [1:0] o_m_tuser;         // [1:0] status

    // table model state
    logic               tbl_valid [SLOTS];
    logic [STAMP_W-1:0] tbl_stamp [SLOTS];
    logic [STAMP_W-1:0] use_ctr;
    int                 tbl_count;

    t_lru_result expected_slot_results [$];
    int          mismatches     = 0;
    int          accepted_items = 0;
    int          burst_left     = 0;

    lru_timestamp_slot_table #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Apply one item to the table model and return the result it produces.
    function automatic t_lru_result lru_table_step(input t_cmd cmd,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic incl);
        t_lru_result        r;
        logic [STAMP_W-1:0] best;
        r.slot   = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_ADD: begin
                if (tbl_count >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    r.slot = IDX_W'(tbl_count);
                    use_ctr = use_ctr + 1'b1;
                    tbl_valid[tbl_count] = 1'b1;
                    tbl_stamp[tbl_count] = use_ctr;
                    tbl_count++;
                end
            end
            CMD_REMOVE: begin
                if (int'(idx) >= tbl_count) begin
                    r.status = ST_RANGE;
                end else begin
                    tbl_valid[idx] = 1'b0;
                    // trim free slots off the end
                    while (tbl_count > 0 && !tbl_valid[tbl_count-1])
                        tbl_count--;
                end
            end
            CMD_USE: begin
                if (int'(idx) >= tbl_count) begin
                    r.status = ST_RANGE;
                end else begin
                    // rescale counter and live stamps before the counter runs out
                    if (use_ctr > RESCALE_LIMIT) begin
                        use_ctr = use_ctr >> RESCALE_SHIFT;
                        for (int i = 0; i < tbl_count; i++)
                            if (tbl_valid[i])
                                tbl_stamp[i] = (tbl_stamp[i] >> RESCALE_SHIFT) + 1'b1;
                    end
                    use_ctr = use_ctr + 1'b1;
                    tbl_stamp[idx] = use_ctr;
                end
            end
            default: begin
                best = use_ctr;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_valid[i] && tbl_stamp[i] < best &&
                        (incl || tbl_stamp[i] != '0)) begin
                        best   = tbl_stamp[i];
                        r.slot = IDX_W'(i);
                    end
                end
                // claim the chosen slot; slot 0 is cleared even when nothing matched
                if (!incl)
                    tbl_stamp[r.slot] = '0;
            end
        endcase
        return r;
    endfunction

    // Offer one item, wait for it to be taken, then queue its expected result.
    task automatic offer_item(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                              input logic incl, input logic typed,
                              input t_lru_result typed_res);
        int          gap;
        t_lru_result r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, incl, idx};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        accepted_items++;
        r = lru_table_step(cmd, idx, incl);
        expected_slot_results.push_back(typed ? typed_res : r);
    endtask

    // Check each delivered result against the oldest expectation.
    always @(posedge i_clk) begin
        t_lru_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_slot_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: slot %0d status %0d",
                             o_m_tdata[5:0], o_m_tuser);
            end else begin
                exp_r = expected_slot_results.pop_front();
                if (o_m_tdata !== {2'b00, exp_r.slot} || o_m_tuser !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"mismatch: expected slot %0d status %0d, ",
                                  "got tdata %0d status %0d"},
                                 exp_r.slot, exp_r.status, o_m_tdata, o_m_tuser);
                end
            end
        end
    end

    // Receiver: stall in changing patterns, with one long hold-off early on.
    initial begin
        int mode;
        int span;
        bit held_off;
        held_off = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && accepted_items >= 40) begin
                held_off = 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    i_m_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            for (int c = 0; c < span; c++) begin
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= c[0];
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Sender: reset, directed table, random segments, then drain.
    initial begin
        t_stim_row   directed_rows [21];
        t_lru_result typed_res;
        t_cmd        cmd;
        logic [IDX_W-1:0] idx;
        int          phase;
        int          seg_len;
        int          pick;
        int          sent;

        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0;
            tbl_stamp[i] = '0;
        end
        use_ctr   = '0;
        tbl_count = 0;

        directed_rows = '{
            // empty table: find in both modes, out-of-range remove and use
            '{CMD_FIND,   6'd0,  1'b0, 1'b1, 6'd0, ST_OK},
            '{CMD_FIND,   6'd0,  1'b1, 1'b1, 6'd0, ST_OK},
            '{CMD_REMOVE, 6'd0,  1'b0, 1'b1, 6'd0, ST_RANGE},
            '{CMD_USE,    6'd63, 1'b1, 1'b1, 6'd0, ST_RANGE},
            // fill three slots
            '{CMD_ADD,    6'd0,  1'b0, 1'b1, 6'd0, ST_OK},
            '{CMD_ADD,    6'd63, 1'b1, 1'b1, 6'd1, ST_OK},
            '{CMD_ADD,    6'd0,  1'b0, 1'b1, 6'd2, ST_OK},
            // restamp, then find with and without claiming
            '{CMD_USE,    6'd1,  1'b0, 1'b0, 6'd0, ST_OK},
            '{CMD_FIND,   6'd0,  1'b1, 1'b0, 6'd0, ST_OK},
            '{CMD_FIND,   6'd0,  1'b0, 1'b0, 6'd0, ST_OK},
            '{CMD_FIND,   6'd0,  1'b0, 1'b0, 6'd0, ST_OK},
            '{CMD_FIND,   6'd0,  1'b1, 1'b0, 6'd0, ST_OK},
            // index equal to the count
            '{CMD_USE,    6'd3,  1'b0, 1'b1, 6'd0, ST_RANGE},
            // trim the tail, remove twice, use a freed slot below the count
            '{CMD_REMOVE, 6'd2,  1'b0, 1'b0, 6'd0, ST_OK},
            '{CMD_REMOVE, 6'd0,  1'b0, 1'b0, 6'd0, ST_OK},
            '{CMD_REMOVE, 6'd0,  1'b1, 1'b0, 6'd0, ST_OK},
            '{CMD_USE,    6'd0,  1'b0, 1'b0, 6'd0, ST_OK},
            '{CMD_FIND,   6'd0,  1'b0, 1'b0, 6'd0, ST_OK},
            // last removal empties the table
            '{CMD_REMOVE, 6'd1,  1'b0, 1'b0, 6'd0, ST_OK},
            '{CMD_FIND,   6'd63, 1'b0, 1'b0, 6'd0, ST_OK},
            '{CMD_REMOVE, 6'd63, 1'b1, 1'b1, 6'd0, ST_RANGE}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            typed_res.slot   = directed_rows[r].slot;
            typed_res.status = directed_rows[r].status;
            offer_item(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].incl,
                       directed_rows[r].typed, typed_res);
        end

        // random segments: fill-heavy, drain-heavy or even mix of commands
        typed_res = '0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase   = $urandom_range(0, 2);
            seg_len = $urandom_range(30, 120);
            for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                case (phase)
                    0: cmd = (pick < 70) ? CMD_ADD : (pick < 85) ? CMD_USE :
                             (pick < 95) ? CMD_FIND : CMD_REMOVE;
                    1: cmd = (pick < 50) ? CMD_REMOVE : (pick < 65) ? CMD_USE :
                             (pick < 90) ? CMD_FIND : CMD_ADD;
                    default: cmd = t_cmd'(pick[1:0]);
                endcase
                // mostly indexes inside the table, sometimes anywhere
                if (tbl_count > 0 && $urandom_range(0, 9) < 8)
                    idx = IDX_W'($urandom_range(0, tbl_count - 1));
                else
                    idx = IDX_W'($urandom_range(0, SLOTS - 1));
                offer_item(cmd, idx, 1'($urandom_range(0, 1)), 1'b0, typed_res);
                sent++;
            end
        end

        i_s_tvalid <= 1'b0;
        while (expected_slot_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_slot_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

endmodule
